[src/binary_turing_machine_step_defines.svh]
// assertion macros shared by the rtl files
`ifndef BINARY_TURING_MACHINE_STEP_DEFINES_SVH
`define BINARY_TURING_MACHINE_STEP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BTM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BTM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/btm_pkg.sv]
package btm_pkg;

  localparam int TAPE_CELLS  = 1024;
  localparam int STATE_COUNT = 64;

  localparam int TAPE_W   = $clog2(TAPE_CELLS);
  localparam int STATE_W  = $clog2(STATE_COUNT);
  localparam int HALF     = TAPE_CELLS / 2;

  // fixed field widths
  localparam int FUNC_W     = 2;
  localparam int SIDX_W     = 6;
  localparam int OFFSET_W   = 10;
  localparam int STATUS_W   = 3;

  // working width for signed tape positions
  localparam int IDX_W = ((TAPE_W > OFFSET_W) ? TAPE_W : OFFSET_W) + 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_RULE = 2'd0,
    FN_LOAD_CELL = 2'd1,
    FN_STEP      = 2'd2,
    FN_RESTART   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STEPPED   = 3'd0,
    ST_HALT      = 3'd1,
    ST_OFF_RIGHT = 3'd2,
    ST_OFF_LEFT  = 3'd3,
    ST_LOAD_DONE = 3'd4
  } status_t;

  typedef struct packed {
    logic              defined;
    logic              write;
    logic              right;
    logic [SIDX_W-1:0] next;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage

[src/btm_ram.sv]
module btm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/btm_ctrl.sv]
`include "binary_turing_machine_step_defines.svh"

module btm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [btm_pkg::FUNC_W-1:0] in_func,
  input  btm_pkg::stat_t             stat,
  output btm_pkg::cmd_t              cmd
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        is_step;

  assign is_step    = btm_pkg::func_t'(in_func) == btm_pkg::FN_STEP;
  assign in_ready   = (state_r == S_IDLE) && stat.out_free;
  assign cmd.clear  = state_r == S_CLEAR;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.exec   = state_r == S_EXEC;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept && is_step) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BTM_ASSERT_IMP(a_no_ready_in_clear, state_r == S_CLEAR, !in_ready, "ready during tape clear")
  `BTM_ASSERT_NXT(a_step_execs, cmd.accept && is_step, cmd.exec, "accepted step not executed")
  `BTM_ASSERT_NXT(a_exec_one_cycle, cmd.exec, state_r == S_IDLE, "execute cycle not followed by idle")

endmodule

[src/btm_dp.sv]
`include "binary_turing_machine_step_defines.svh"

module btm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  btm_pkg::cmd_t                       cmd,
  output btm_pkg::stat_t                      stat,
  input  logic [btm_pkg::FUNC_W-1:0]          in_func,
  input  logic [btm_pkg::SIDX_W-1:0]          in_state_index,
  input  logic                                in_read_symbol,
  input  logic                                in_rule_defined,
  input  logic                                in_write_bit,
  input  logic                                in_move_right,
  input  logic [btm_pkg::SIDX_W-1:0]          in_next_state,
  input  logic signed [btm_pkg::OFFSET_W-1:0] in_cell_offset,
  input  logic                                in_cell_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [btm_pkg::STATUS_W-1:0]        out_status,
  output logic signed [btm_pkg::OFFSET_W-1:0] out_head_offset,
  output logic [btm_pkg::SIDX_W-1:0]          out_machine_state,
  output logic                                out_read_bit
);

  logic [btm_pkg::TAPE_W-1:0]                  head_r, head_nxt;
  logic [btm_pkg::STATE_W-1:0]                 state_r, state_nxt;
  logic                                        stopped_r, stopped_nxt;
  btm_pkg::status_t                            code_r, code_nxt;
  logic [1:0][btm_pkg::STATE_COUNT-1:0]        rvld_r, rvld_nxt;
  logic [btm_pkg::TAPE_W-1:0]                  clr_addr_r, clr_addr_nxt;

  logic                                        out_valid_r;
  btm_pkg::status_t                            out_status_r;
  logic signed [btm_pkg::OFFSET_W-1:0]         out_head_r;
  logic [btm_pkg::SIDX_W-1:0]                  out_state_r;
  logic                                        out_rbit_r;

  logic                                        o_load;
  btm_pkg::status_t                            o_status;
  logic                                        o_rbit;

  logic                                        t_we;
  logic [btm_pkg::TAPE_W-1:0]                  t_waddr;
  logic                                        t_wdata;
  logic                                        t_rdata;

  logic [1:0]                                  r_we;
  logic [btm_pkg::STATE_W-1:0]                 r_waddr;
  btm_pkg::rule_t                              r_wdata;
  btm_pkg::rule_t [1:0]                        r_rdata;

  btm_pkg::rule_t                              rule_sel;
  logic                                        rule_ok;
  logic                                        rule_state_ok;
  logic signed [btm_pkg::IDX_W-1:0]            cell_idx;
  logic                                        cell_in_range;
  logic [btm_pkg::IDX_W-1:0]                   pos_full;

  // tape store: cleared by the sweep after reset
  btm_ram #(
    .WIDTH (1),
    .DEPTH (btm_pkg::TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (head_r),
    .rdata (t_rdata)
  );

  // one rule store per read symbol, both read at the current state
  for (genvar s = 0; s < 2; s++) begin : g_rule
    btm_ram #(
      .WIDTH (btm_pkg::RULE_W),
      .DEPTH (btm_pkg::STATE_COUNT)
    ) u_rule (
      .clk   (clk),
      .we    (r_we[s]),
      .waddr (r_waddr),
      .wdata (r_wdata),
      .raddr (state_r),
      .rdata (r_rdata[s])
    );
  end

  assign rule_sel      = t_rdata ? r_rdata[1] : r_rdata[0];
  assign rule_ok       = rvld_r[t_rdata][state_r] && rule_sel.defined;
  assign rule_state_ok = int'(in_state_index) < btm_pkg::STATE_COUNT;
  assign cell_idx      = btm_pkg::IDX_W'(in_cell_offset) + btm_pkg::IDX_W'(btm_pkg::HALF);
  assign cell_in_range = !cell_idx[btm_pkg::IDX_W-1] &&
                         (cell_idx < btm_pkg::IDX_W'(btm_pkg::TAPE_CELLS));
  assign r_waddr       = btm_pkg::STATE_W'(in_state_index);
  assign r_wdata       = '{defined: in_rule_defined, write: in_write_bit,
                           right: in_move_right, next: in_next_state};
  assign pos_full      = btm_pkg::IDX_W'(head_nxt) - btm_pkg::IDX_W'(btm_pkg::HALF);

  always_comb begin
    head_nxt     = head_r;
    state_nxt    = state_r;
    stopped_nxt  = stopped_r;
    code_nxt     = code_r;
    rvld_nxt     = rvld_r;
    clr_addr_nxt = clr_addr_r;
    t_we         = 1'b0;
    t_waddr      = head_r;
    t_wdata      = 1'b0;
    r_we         = '0;
    o_load       = 1'b0;
    o_status     = btm_pkg::ST_LOAD_DONE;
    o_rbit       = 1'b0;

    if (cmd.clear) begin
      t_we         = 1'b1;
      t_waddr      = clr_addr_r;
      clr_addr_nxt = clr_addr_r + 1'b1;
    end

    if (cmd.accept) begin
      o_load = 1'b1;
      unique case (btm_pkg::func_t'(in_func))
        btm_pkg::FN_LOAD_RULE: begin
          if (rule_state_ok) begin
            r_we[in_read_symbol]              = 1'b1;
            rvld_nxt[in_read_symbol][r_waddr] = 1'b1;
          end
        end
        btm_pkg::FN_LOAD_CELL: begin
          if (cell_in_range) begin
            t_we    = 1'b1;
            t_waddr = btm_pkg::TAPE_W'(cell_idx);
            t_wdata = in_cell_value;
          end
        end
        btm_pkg::FN_RESTART: begin
          head_nxt    = btm_pkg::TAPE_W'(btm_pkg::HALF);
          state_nxt   = btm_pkg::STATE_W'(in_state_index);
          stopped_nxt = 1'b0;
          code_nxt    = btm_pkg::ST_STEPPED;
        end
        btm_pkg::FN_STEP: begin
          // result comes from the execute cycle
          o_load = 1'b0;
        end
      endcase
    end

    if (cmd.exec) begin
      o_load = 1'b1;
      if (stopped_r) begin
        o_status = code_r;
      end else if (!rule_ok) begin
        stopped_nxt = 1'b1;
        code_nxt    = btm_pkg::ST_HALT;
        o_status    = btm_pkg::ST_HALT;
        o_rbit      = t_rdata;
      end else begin
        t_we    = 1'b1;
        t_waddr = head_r;
        t_wdata = rule_sel.write;
        o_rbit  = t_rdata;
        if (rule_sel.right) begin
          if (head_r == btm_pkg::TAPE_W'(btm_pkg::TAPE_CELLS - 1)) begin
            stopped_nxt = 1'b1;
            code_nxt    = btm_pkg::ST_OFF_RIGHT;
            o_status    = btm_pkg::ST_OFF_RIGHT;
          end else begin
            head_nxt  = head_r + 1'b1;
            state_nxt = btm_pkg::STATE_W'(rule_sel.next);
            o_status  = btm_pkg::ST_STEPPED;
          end
        end else begin
          if (head_r == '0) begin
            stopped_nxt = 1'b1;
            code_nxt    = btm_pkg::ST_OFF_LEFT;
            o_status    = btm_pkg::ST_OFF_LEFT;
          end else begin
            head_nxt  = head_r - 1'b1;
            state_nxt = btm_pkg::STATE_W'(rule_sel.next);
            o_status  = btm_pkg::ST_STEPPED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= btm_pkg::TAPE_W'(btm_pkg::HALF);
      state_r     <= '0;
      stopped_r   <= 1'b0;
      code_r      <= btm_pkg::ST_STEPPED;
      rvld_r      <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      state_r    <= state_nxt;
      stopped_r  <= stopped_nxt;
      code_r     <= code_nxt;
      rvld_r     <= rvld_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (o_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_status_r <= o_status;
      out_head_r   <= $signed(pos_full[btm_pkg::OFFSET_W-1:0]);
      out_state_r  <= btm_pkg::SIDX_W'(state_nxt);
      out_rbit_r   <= o_rbit;
    end
  end

  assign stat.clear_last = clr_addr_r == btm_pkg::TAPE_W'(btm_pkg::TAPE_CELLS - 1);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_head_offset   = out_head_r;
  assign out_machine_state = out_state_r;
  assign out_read_bit      = out_rbit_r;

  `BTM_ASSERT_NXT(a_stop_sticks, stopped_r && !(cmd.accept && btm_pkg::func_t'(in_func) == btm_pkg::FN_RESTART), stopped_r, "stopped flag dropped without restart")
  `BTM_ASSERT_NXT(a_stopped_head_still, cmd.exec && stopped_r, $stable(head_r) && $stable(state_r), "stopped machine moved")
  `BTM_ASSERT_IMP(a_no_load_while_full, o_load, stat.out_free, "result overwrites one not yet taken")

endmodule

[src/binary_turing_machine_step.sv]
// two-symbol turing machine, one command per input transaction
// load rule, load cell, restart: result registered the next cycle, one per cycle if out_ready
// step: tape ram read, then execute cycle writes back and loads the result; in_ready low in execute
// reset (synchronous, active low) starts a sweep clearing all 1024 tape cells, in_ready low throughout
// rule valid bits, head, state and stop flag clear at once; head goes to the tape centre
module binary_turing_machine_step (
  input  logic                                clk,
  input  logic                                rst_n,
  // input transactions
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [btm_pkg::FUNC_W-1:0]          in_func,
  input  logic [btm_pkg::SIDX_W-1:0]          in_state_index,
  input  logic                                in_read_symbol,
  input  logic                                in_rule_defined,
  input  logic                                in_write_bit,
  input  logic                                in_move_right,
  input  logic [btm_pkg::SIDX_W-1:0]          in_next_state,
  input  logic signed [btm_pkg::OFFSET_W-1:0] in_cell_offset,
  input  logic                                in_cell_value,
  // result transactions
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [btm_pkg::STATUS_W-1:0]        out_status,
  output logic signed [btm_pkg::OFFSET_W-1:0] out_head_offset,
  output logic [btm_pkg::SIDX_W-1:0]          out_machine_state,
  output logic                                out_read_bit
);

  // command and status bundles between the sequencer and the datapath
  btm_pkg::cmd_t  cmd;
  btm_pkg::stat_t stat;

  // sequencer: clearing sweep, idle, execute cycle of a step
  // in_ready also waits for the output register to be free or draining
  btm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: tape and rule rams, head and state registers, output register
  // a step reads the tape cell and both rules of the current state in the
  // acceptance cycle, then picks the rule, writes the cell and moves the head
  btm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_func),
    .in_state_index    (in_state_index),
    .in_read_symbol    (in_read_symbol),
    .in_rule_defined   (in_rule_defined),
    .in_write_bit      (in_write_bit),
    .in_move_right     (in_move_right),
    .in_next_state     (in_next_state),
    .in_cell_offset    (in_cell_offset),
    .in_cell_value     (in_cell_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_head_offset   (out_head_offset),
    .out_machine_state (out_machine_state),
    .out_read_bit      (out_read_bit)
  );

endmodule
